FILE: hw/rtl/pdd_pkg.sv
package pdd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int REL_WIDTH   = 14;   // release delay after the x64 option
  localparam int CFG_WIDTH   = 16;
  localparam int INDEX_WIDTH = 3;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [7:0] ERROR_MAX = 8'd255;

  // release delay from the filter: (925 - filt) / 4, at least 1
  localparam logic [9:0] POT_SPAN       = 10'd925;
  localparam logic [9:0] POT_CLAMP_AT   = 10'd920;
  localparam logic [9:0] FIXED_LIMIT    = 10'd512;
  localparam int         LONG_SHIFT     = 6;

  typedef enum logic [INDEX_WIDTH-1:0] {
    REG_DETECT_THRESHOLD = 3'd0,
    REG_ASSERT_DELAY     = 3'd1,
    REG_RELEASE_FROM_POT = 3'd2,
    REG_FIXED_RELEASE    = 3'd3,
    REG_SLOW_RELEASE     = 3'd4,
    REG_LINE_MODE        = 3'd5
  } reg_index_t;

  localparam logic [1:0] LINE_COMPLEMENT = 2'd0;
  localparam logic [1:0] LINE_FOLLOW     = 2'd1;
  localparam logic [1:0] LINE_PULSE      = 2'd2;
  localparam logic [1:0] LINE_SPARE      = 2'd3;   // acts as complementary

  localparam logic [15:0] RST_DETECT_THRESHOLD = 16'h0300;
  localparam logic [7:0]  RST_ASSERT_DELAY     = 8'd1;
  localparam logic        RST_RELEASE_FROM_POT = 1'b1;
  localparam logic [7:0]  RST_FIXED_RELEASE    = 8'd10;
  localparam logic        RST_SLOW_RELEASE     = 1'b0;
  localparam logic [1:0]  RST_LINE_MODE        = LINE_COMPLEMENT;

  typedef struct packed {
    logic [15:0] detect_threshold;
    logic [7:0]  assert_delay;
    logic        release_from_pot;
    logic [7:0]  fixed_release;
    logic        slow_release;
    logic [1:0]  line_mode;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  pot_sample;
    logic [15:0] proximity;
    logic        sensor_ack;
  } in_word_t;

  typedef struct packed {
    logic       detected;
    logic       line_present;
    logic       line_absent;
    logic       reinit_request;
    logic [9:0] filtered_level;
  } out_word_t;

endpackage

FILE: hw/rtl/pdd_cfg_regs.sv
module pdd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pdd_pkg::INDEX_WIDTH-1:0]  cfg_index,
  input  logic [pdd_pkg::CFG_WIDTH-1:0]    cfg_data,
  output pdd_pkg::cfg_t                    cfg
);
  import pdd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_threshold <= RST_DETECT_THRESHOLD;
      cfg.assert_delay     <= RST_ASSERT_DELAY;
      cfg.release_from_pot <= RST_RELEASE_FROM_POT;
      cfg.fixed_release    <= RST_FIXED_RELEASE;
      cfg.slow_release     <= RST_SLOW_RELEASE;
      cfg.line_mode        <= RST_LINE_MODE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DETECT_THRESHOLD: cfg.detect_threshold <= cfg_data;
        REG_ASSERT_DELAY:     cfg.assert_delay     <= cfg_data[7:0];
        REG_RELEASE_FROM_POT: cfg.release_from_pot <= cfg_data[0];
        REG_FIXED_RELEASE:    cfg.fixed_release    <= cfg_data[7:0];
        REG_SLOW_RELEASE:     cfg.slow_release     <= cfg_data[0];
        REG_LINE_MODE:        cfg.line_mode        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pdd_filter.sv
module pdd_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [9:0]                      sample,
  input  pdd_pkg::cfg_t                   cfg,
  output logic [9:0]                      filt_next,
  output logic [pdd_pkg::REL_WIDTH-1:0]   release_delay
);
  import pdd_pkg::*;

  logic [9:0]         filt;
  logic signed [10:0] diff;
  logic signed [10:0] quot;
  logic signed [10:0] sum;
  logic [9:0]         span;
  logic [7:0]         rel_base;

  always_comb begin
    diff = $signed({1'b0, sample}) - $signed({1'b0, filt});
    // divide by 4 rounding toward zero
    quot = diff[10] ? ((diff + 11'sd3) >>> 2) : (diff >>> 2);
    sum  = $signed({1'b0, filt}) + quot;
    filt_next = sum[9:0];

    span = POT_SPAN - filt_next;
    if (cfg.release_from_pot) begin
      rel_base = (filt_next > POT_CLAMP_AT) ? 8'd1 : span[9:2];
    end else begin
      rel_base = (filt_next > FIXED_LIMIT) ? 8'd0 : cfg.fixed_release;
    end

    if (cfg.slow_release) begin
      release_delay = REL_WIDTH'({rel_base, {LONG_SHIFT{1'b0}}});
    end else begin
      release_delay = REL_WIDTH'(rel_base);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt <= '0;
    end else if (step) begin
      filt <= filt_next;
    end
  end

endmodule

FILE: hw/rtl/pdd_debounce.sv
module pdd_debounce (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [15:0]                    proximity,
  input  logic                           sensor_ack,
  input  logic [pdd_pkg::REL_WIDTH-1:0]  release_delay,
  input  pdd_pkg::cfg_t                  cfg,
  output logic                           detected,
  output logic                           line_present,
  output logic                           line_absent,
  output logic                           reinit_request
);
  import pdd_pkg::*;

  logic [COUNT_WIDTH-1:0] hold_count;
  logic [COUNT_WIDTH-1:0] hold_count_next;
  logic [COUNT_WIDTH-1:0] hold_inc;
  logic                   detect_flag;
  logic                   detect_flag_next;
  logic [7:0]             error_count;
  logic [7:0]             error_count_next;
  logic                   present_line;
  logic                   present_line_next;
  logic                   absent_line;
  logic                   absent_line_next;
  logic                   present;

  always_comb begin
    present  = proximity >= cfg.detect_threshold;
    hold_inc = (hold_count == COUNT_MAX) ? hold_count : hold_count + 1'b1;

    detect_flag_next = detect_flag;
    hold_count_next  = '0;
    if (!sensor_ack) begin
      error_count_next = (error_count == ERROR_MAX) ? error_count : error_count + 1'b1;
      detect_flag_next = 1'b0;
    end else begin
      error_count_next = '0;
      if (!detect_flag && present) begin
        if (hold_inc > COUNT_WIDTH'(cfg.assert_delay)) begin
          detect_flag_next = 1'b1;
        end else begin
          hold_count_next = hold_inc;
        end
      end else if (detect_flag && !present) begin
        if (hold_inc > COUNT_WIDTH'(release_delay)) begin
          detect_flag_next = 1'b0;
        end else begin
          hold_count_next = hold_inc;
        end
      end
    end
  end

  always_comb begin
    present_line_next = present_line;
    absent_line_next  = absent_line;
    case (cfg.line_mode)
      LINE_FOLLOW: begin
        present_line_next = detect_flag_next;
        absent_line_next  = detect_flag_next;
      end
      LINE_PULSE: begin
        // a change raises one line and leaves the other alone
        if (detect_flag != detect_flag_next) begin
          if (detect_flag) begin
            absent_line_next = 1'b1;
          end else begin
            present_line_next = 1'b1;
          end
        end else begin
          present_line_next = 1'b0;
          absent_line_next  = 1'b0;
        end
      end
      default: begin
        present_line_next = detect_flag_next;
        absent_line_next  = !detect_flag_next;
      end
    endcase
  end

  assign detected       = detect_flag_next;
  assign line_present   = present_line_next;
  assign line_absent    = absent_line_next;
  assign reinit_request = error_count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count   <= '0;
      detect_flag  <= 1'b0;
      error_count  <= '0;
      present_line <= 1'b0;
      absent_line  <= 1'b1;
    end else if (step) begin
      hold_count   <= hold_count_next;
      detect_flag  <= detect_flag_next;
      error_count  <= error_count_next;
      present_line <= present_line_next;
      absent_line  <= absent_line_next;
    end
  end

endmodule

FILE: hw/rtl/proximity_detect_debouncer_unit.sv
// Proximity detector with asymmetric debounce. Each word is one sensor tick;
// the unit takes one word per clock while no result is stalled and returns one
// result word per tick, in order. An accepted word is loaded into the input
// register; the filter/debounce update then writes the result register once no
// earlier result is stalled. Sustained rate is one word per cycle when the
// output is not stalled, set by the combinational state update between the
// two registers. A stalled result holds the input register; a new word is
// still taken while a result waits, until both stages are full.
// Configuration registers are written through cfg_write/cfg_index.
module proximity_detect_debouncer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pdd_pkg::in_word_t                in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pdd_pkg::out_word_t               out_word,
  input  logic                             cfg_write,
  input  logic [pdd_pkg::INDEX_WIDTH-1:0]  cfg_index,
  input  logic [pdd_pkg::CFG_WIDTH-1:0]    cfg_data
);
  import pdd_pkg::*;

  cfg_t                   cfg;
  in_word_t               in_reg;
  logic                   in_full;
  logic                   advance;
  logic                   step;
  logic [9:0]             filt_next;
  logic [REL_WIDTH-1:0]   release_delay;
  out_word_t              result;

  assign advance  = !out_valid || !out_stall;
  assign step     = in_full && advance;
  assign in_stall = in_full && !advance;

  pdd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdd_filter u_filter (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .sample        (in_reg.pot_sample),
    .cfg           (cfg),
    .filt_next     (filt_next),
    .release_delay (release_delay)
  );

  pdd_debounce u_debounce (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .proximity      (in_reg.proximity),
    .sensor_ack     (in_reg.sensor_ack),
    .release_delay  (release_delay),
    .cfg            (cfg),
    .detected       (result.detected),
    .line_present   (result.line_present),
    .line_absent    (result.line_absent),
    .reinit_request (result.reinit_request)
  );

  assign result.filtered_level = filt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= result;
    end
  end

endmodule

FILE: hw/rtl/pdd_checker.sv
module pdd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input pdd_pkg::out_word_t               out_word
);

  // nothing comes out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // input only backs up when a result is waiting and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // a result is on the output after an accepted word passes the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> ##2 out_valid)
    else $error("accepted word produced no result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result changed");

endmodule

bind proximity_detect_debouncer_unit pdd_checker u_pdd_checker (.*);
